[sv/mru_history_dedupe_core_defines.svh]
// ----------------------------------------------------------------------------
// mru_history_dedupe_core_defines
// Assertion macros used by the MRU history dedupe datapath.
// ----------------------------------------------------------------------------
`ifndef MRU_HISTORY_DEDUPE_CORE_DEFINES_SVH
`define MRU_HISTORY_DEDUPE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MHD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MHD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MHD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`define MHD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[sv/mhd_pkg.sv]
// ----------------------------------------------------------------------------
// mhd_pkg
// Types and constants for the MRU history dedupe block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhd_pkg;

   localparam int ID_MAX_BYTES = 22;
   localparam int ID_W         = 8 * ID_MAX_BYTES;
   localparam int LOW_W        = 64;
   localparam int MID_W        = 64;
   localparam int HIGH_W       = 48;
   localparam int IDX_W        = 3;
   localparam int STATUS_W     = 3;
   localparam int COUNT_W      = 4;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_READ    = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_NEWEST  = 3'd2,
      ST_MOVED   = 3'd3,
      ST_ADDED   = 3'd4,
      ST_DROPPED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic capture;
      logic compare;
      logic update;
   } cmd_type;

   // bits 0..k set
   function automatic logic [ID_MAX_BYTES-1:0] upto_mask(input int k);
      logic [ID_MAX_BYTES-1:0] m;
      for (int j = 0; j < ID_MAX_BYTES; j++) begin
         m[j] = (j <= k);
      end
      return m;
   endfunction

endpackage

[sv/mhd_ctrl.sv]
// ----------------------------------------------------------------------------
// mhd_ctrl
// Sequencer: capture, compare against all cells, update and respond.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhd_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output mhd_pkg::cmd_type cmd
);

   mhd_pkg::state_type state_ff;
   mhd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         mhd_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = mhd_pkg::S_COMPARE;
            end
         end
         mhd_pkg::S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = mhd_pkg::S_UPDATE;
         end
         mhd_pkg::S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = mhd_pkg::S_IDLE;
         end
         default: begin
            state_in = mhd_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[sv/mhd_datapath.sv]
// ----------------------------------------------------------------------------
// mhd_datapath
// History cells, per-cell match, move-to-front shift and response registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "mru_history_dedupe_core_defines.svh"

module mhd_datapath #(
   parameter int HISTORY_DEPTH = 8,
   parameter int ID_BYTES      = 22
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mhd_pkg::cmd_type                  cmd,
   input  logic                              req_operation,
   input  logic [mhd_pkg::LOW_W-1:0]         req_id_low,
   input  logic [mhd_pkg::MID_W-1:0]         req_id_mid,
   input  logic [mhd_pkg::HIGH_W-1:0]        req_id_high,
   input  logic [mhd_pkg::IDX_W-1:0]         req_read_index,
   output logic                              rsp_valid,
   output logic [mhd_pkg::STATUS_W-1:0]      rsp_status,
   output logic [mhd_pkg::LOW_W-1:0]         rsp_entry_low,
   output logic [mhd_pkg::MID_W-1:0]         rsp_entry_mid,
   output logic [mhd_pkg::HIGH_W-1:0]        rsp_entry_high,
   output logic [mhd_pkg::COUNT_W-1:0]       rsp_entry_count
);

   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int NB    = mhd_pkg::ID_MAX_BYTES;
   localparam int IW    = mhd_pkg::ID_W;

   // request capture
   logic [IW-1:0]               raw_id;
   logic [NB-1:0]               zero_b;
   logic [NB-1:0]               keep;
   logic [IW-1:0]               clean_id;
   logic [IW-1:0]               id_ff;
   logic                        op_ff;
   logic [mhd_pkg::IDX_W-1:0]   idx_ff;

   // cells
   logic [IW-1:0]               hist_ff [HISTORY_DEPTH];
   logic [CNT_W-1:0]            cnt_ff;
   logic [CNT_W-1:0]            cnt_in;
   logic [HISTORY_DEPTH-1:0]    match_ff;
   logic [HISTORY_DEPTH-1:0]    match_in;
   logic [HISTORY_DEPTH-1:0]    none_before;

   // update decode
   logic                        is_read;
   logic                        is_empty;
   logic                        do_write;
   mhd_pkg::status_type         status;
   logic [IW-1:0]               read_data;
   logic [CNT_W+3:0]            cnt_ext;

   // response
   logic                        rsp_valid_ff;
   logic [mhd_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [IW-1:0]               rsp_entry_ff;
   logic [mhd_pkg::COUNT_W-1:0] rsp_count_ff;

   assign raw_id = {req_id_high, req_id_mid, req_id_low};

   always_comb begin
      for (int k = 0; k < NB; k++) begin
         zero_b[k] = (raw_id[8*k +: 8] == 8'h00);
      end
      for (int k = 0; k < NB; k++) begin
         keep[k] = (k < ID_BYTES) && ((zero_b & mhd_pkg::upto_mask(k)) == '0);
         clean_id[8*k +: 8] = keep[k] ? raw_id[8*k +: 8] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         id_ff  <= clean_id;
         op_ff  <= req_operation;
         idx_ff <= req_read_index;
      end
   end

   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         match_in[i] = (hist_ff[i] == id_ff) && (CNT_W'(i) < cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_ff <= match_in;
      end
   end

   always_comb begin
      logic [HISTORY_DEPTH-1:0] below;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         for (int j = 0; j < HISTORY_DEPTH; j++) begin
            below[j] = (j < i);
         end
         none_before[i] = ~|(match_ff & below);
      end
   end

   assign is_read  = (op_ff == mhd_pkg::OP_READ);
   assign is_empty = (id_ff[7:0] == 8'h00);

   always_comb begin
      cnt_in   = cnt_ff;
      do_write = 1'b0;
      priority if (is_read) begin
         status = mhd_pkg::ST_READ;
      end else if (is_empty) begin
         status = mhd_pkg::ST_EMPTY;
      end else if (match_ff[0]) begin
         status = mhd_pkg::ST_NEWEST;
      end else if (|match_ff) begin
         status   = mhd_pkg::ST_MOVED;
         do_write = 1'b1;
      end else if (cnt_ff < CNT_W'(HISTORY_DEPTH)) begin
         status   = mhd_pkg::ST_ADDED;
         do_write = 1'b1;
         cnt_in   = cnt_ff + CNT_W'(1);
      end else begin
         status   = mhd_pkg::ST_DROPPED;
         do_write = 1'b1;
      end
   end

   always_comb begin
      read_data = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if (i < 8) begin
            if ((idx_ff == mhd_pkg::IDX_W'(i)) && (CNT_W'(i) < cnt_ff)) begin
               read_data = read_data | hist_ff[i];
            end
         end
      end
   end

   assign cnt_ext = {4'b0000, cnt_in};

   always_ff @(posedge clock) begin
      if (cmd.update && do_write) begin
         hist_ff[0] <= id_ff;
         for (int i = 1; i < HISTORY_DEPTH; i++) begin
            if (none_before[i]) begin
               hist_ff[i] <= hist_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
         if (cmd.update) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_status_ff <= status;
         rsp_entry_ff  <= is_read ? read_data : '0;
         rsp_count_ff  <= cnt_ext[3:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_low   = rsp_entry_ff[mhd_pkg::LOW_W-1:0];
   assign rsp_entry_mid   = rsp_entry_ff[mhd_pkg::LOW_W +: mhd_pkg::MID_W];
   assign rsp_entry_high  = rsp_entry_ff[mhd_pkg::LOW_W + mhd_pkg::MID_W +: mhd_pkg::HIGH_W];
   assign rsp_entry_count = rsp_count_ff;

   `MHD_ASSERT_IMPLIES(a_cnt_bound, clock, reset, 1'b1,
      cnt_ff <= CNT_W'(HISTORY_DEPTH), "count exceeds depth")
   `MHD_ASSERT_NEXT(a_cnt_hold, clock, reset, !cmd.update,
      $stable(cnt_ff), "count changed outside update")
   `MHD_ASSERT_NEXT(a_rsp_after_update, clock, reset, cmd.update,
      rsp_valid_ff, "no strobe after update")

endmodule

[sv/mru_history_dedupe_core.sv]
// ----------------------------------------------------------------------------
// mru_history_dedupe_core
// Newest-first identifier history without duplicates, with move-to-front.
//
//   channel  ports                          handshake
//   request  req_* fields                   start high, busy low
//   result   rsp_* fields                   rsp_valid for one cycle
//
// A transaction runs capture and clean, then a compare against every cell,
// then shift/insert; the result strobes in the cycle after that.
// busy drops while the strobe shows, so the next start can be taken in the strobe cycle.
// Synchronous reset empties the history (count to zero); cell contents are
// not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mru_history_dedupe_core #(
   parameter int HISTORY_DEPTH = 8,
   parameter int ID_BYTES      = 22
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [mhd_pkg::LOW_W-1:0]     req_id_low,
   input  logic [mhd_pkg::MID_W-1:0]     req_id_mid,
   input  logic [mhd_pkg::HIGH_W-1:0]    req_id_high,
   input  logic [mhd_pkg::IDX_W-1:0]     req_read_index,
   output logic                          rsp_valid,
   output logic [mhd_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mhd_pkg::LOW_W-1:0]     rsp_entry_low,
   output logic [mhd_pkg::MID_W-1:0]     rsp_entry_mid,
   output logic [mhd_pkg::HIGH_W-1:0]    rsp_entry_high,
   output logic [mhd_pkg::COUNT_W-1:0]   rsp_entry_count
);

   mhd_pkg::cmd_type cmd;

   mhd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   mhd_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .ID_BYTES      (ID_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_id_low      (req_id_low),
      .req_id_mid      (req_id_mid),
      .req_id_high     (req_id_high),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_low   (rsp_entry_low),
      .rsp_entry_mid   (rsp_entry_mid),
      .rsp_entry_high  (rsp_entry_high),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
